// ===== src/tdq_pkg.sv =====
// tdq_pkg: shared sizes, codes and struct types for the timer deadline queue.
// No dependencies; the controller, datapath and top level import it.

package tdq_pkg;

   localparam int DEPTH   = 16;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int OCC_W   = $clog2(DEPTH + 1);
   localparam int MAX_OUT = 16;
   localparam int EMIT_W  = $clog2(MAX_OUT + 1);
   localparam int TICK_W  = 32;
   localparam int DELAY_W = 20;
   localparam int KEY_W   = 16;
   localparam int KIND_W  = 2;

   localparam logic CMD_TICK     = 1'b0;
   localparam logic CMD_SCHEDULE = 1'b1;

   localparam logic [KIND_W-1:0] KIND_EXPIRED  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ACCEPTED = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd2;

   // source of a result loaded into the output register
   localparam logic [1:0] PUSH_PEND   = 2'd0;
   localparam logic [1:0] PUSH_ACCEPT = 2'd1;
   localparam logic [1:0] PUSH_REJECT = 2'd2;

   typedef struct packed {
      logic               cmd;
      logic [DELAY_W-1:0] delay;
      logic [KEY_W-1:0]   key;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [KEY_W-1:0]  expired_key;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic       capture;
      logic       tick_inc;
      logic       sched_write;
      logic       scan_clear;
      logic       scan_issue;
      logic       take_best;
      logic       rm_read;
      logic       rm_write;
      logic       push;
      logic [1:0] push_src;
      logic       push_last;
   } ctl_cmd_type;

   typedef struct packed {
      logic in_sched;
      logic full;
      logic issue_done;
      logic pipe_busy;
      logic best_vld;
      logic pend_vld;
      logic out_free;
      logic cnt_max;
   } ctl_status_type;

endpackage

// ===== src/timer_deadline_queue.sv =====
// timer_deadline_queue: top level of the earliest-deadline timer queue.
// Depends on tdq_pkg; instantiates tdq_controller and tdq_datapath.
//
//   channel  direction  handshake              payload
//   req_     in         req_valid / req_stall  tdq_pkg::req_type (cmd, delay, key)
//   rsp_     out        rsp_valid / rsp_stall  tdq_pkg::rsp_type (kind, expired_key, last)
//
// Each pick of a tick request scans the entry memory one slot per cycle through its
// single read port, and each pop moves the last slot into the hole.
// Reset clears the tick count, occupancy and output register; the entry memory is not.
// A stalled result holds in the output register; a new request waits until idle.

module timer_deadline_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tdq_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tdq_pkg::rsp_type rsp_payload
);
   import tdq_pkg::*;

   ctl_cmd_type    ctl_cmd;
   ctl_status_type ctl_status;

   // sequence: accept, then schedule or scan/pop rounds
   tdq_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (ctl_status),
      .cmd       (ctl_cmd)
   );

   // storage, age compare pipeline and result register
   tdq_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (ctl_cmd),
      .status      (ctl_status),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== src/tdq_datapath.sv =====
// tdq_datapath: tick counter, entry memory, due-entry scan pipeline and output register.
// Depends on tdq_pkg; driven by tdq_controller through command and status structs.

module tdq_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  tdq_pkg::req_type        req_payload,
   input  tdq_pkg::ctl_cmd_type    cmd,
   output tdq_pkg::ctl_status_type status,
   input  logic                    rsp_stall,
   output logic                    rsp_valid,
   output tdq_pkg::rsp_type        rsp_payload
);
   import tdq_pkg::*;

   logic [TICK_W-1:0] mem_deadline [DEPTH];
   logic [KEY_W-1:0]  mem_key      [DEPTH];

   req_type           req_ff;
   logic [TICK_W-1:0] tick_ff;
   logic [OCC_W-1:0]  occ_ff;
   logic [OCC_W-1:0]  scan_idx_ff;
   logic [TICK_W-1:0] rd_deadline_ff;
   logic [KEY_W-1:0]  rd_key_ff;
   logic              s1_vld_ff;
   logic [IDX_W-1:0]  s1_idx_ff;
   logic              s2_vld_ff;
   logic [TICK_W-1:0] age_ff;
   logic [KEY_W-1:0]  key2_ff;
   logic [IDX_W-1:0]  idx2_ff;
   logic              best_vld_ff;
   logic [TICK_W-1:0] best_age_ff;
   logic [KEY_W-1:0]  best_key_ff;
   logic [IDX_W-1:0]  best_idx_ff;
   logic              pend_vld_ff;
   logic [KEY_W-1:0]  pend_key_ff;
   logic [EMIT_W-1:0] emit_cnt_ff;
   logic              rsp_vld_ff;
   rsp_type           rsp_ff;
   rsp_type           rsp_in;

   logic              issue;
   logic              issue_done;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [TICK_W-1:0] wr_deadline;
   logic [KEY_W-1:0]  wr_key;
   logic [OCC_W-1:0]  occ_m1;
   logic              better;

   assign occ_m1     = occ_ff - OCC_W'(1);
   assign issue_done = (scan_idx_ff == occ_ff);
   assign issue      = cmd.scan_issue && !issue_done;
   assign rd_en      = issue || cmd.rm_read;
   assign rd_addr    = cmd.rm_read ? occ_m1[IDX_W-1:0] : scan_idx_ff[IDX_W-1:0];
   assign wr_en      = cmd.sched_write || cmd.rm_write;
   assign wr_addr    = cmd.rm_write ? best_idx_ff : occ_ff[IDX_W-1:0];
   assign wr_deadline = cmd.rm_write ? rd_deadline_ff
                                     : tick_ff + TICK_W'(req_ff.delay);
   assign wr_key     = cmd.rm_write ? rd_key_ff : req_ff.key;

   // entry is due when the wrapped age has its top bit clear; keep the oldest,
   // lower key wins on equal age, first slot wins on a full tie
   assign better = s2_vld_ff && !age_ff[TICK_W-1] &&
                   (!best_vld_ff || (age_ff > best_age_ff) ||
                    ((age_ff == best_age_ff) && (key2_ff < best_key_ff)));

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_deadline_ff <= mem_deadline[rd_addr];
         rd_key_ff      <= mem_key[rd_addr];
      end
      if (wr_en) begin
         mem_deadline[wr_addr] <= wr_deadline;
         mem_key[wr_addr]      <= wr_key;
      end
   end

   always_comb begin
      rsp_in = '0;
      unique case (cmd.push_src)
         PUSH_PEND: begin
            rsp_in.kind        = KIND_EXPIRED;
            rsp_in.expired_key = pend_key_ff;
            rsp_in.last        = cmd.push_last;
         end
         PUSH_ACCEPT: begin
            rsp_in.kind = KIND_ACCEPTED;
            rsp_in.last = 1'b1;
         end
         PUSH_REJECT: begin
            rsp_in.kind = KIND_REJECTED;
            rsp_in.last = 1'b1;
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff     <= '0;
         occ_ff      <= '0;
         scan_idx_ff <= '0;
         s1_vld_ff   <= 1'b0;
         s2_vld_ff   <= 1'b0;
         best_vld_ff <= 1'b0;
         pend_vld_ff <= 1'b0;
         emit_cnt_ff <= '0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         if (cmd.tick_inc) begin
            tick_ff <= tick_ff + TICK_W'(1);
         end
         if (cmd.sched_write) begin
            occ_ff <= occ_ff + OCC_W'(1);
         end else if (cmd.rm_write) begin
            occ_ff <= occ_m1;
         end
         if (cmd.scan_clear) begin
            scan_idx_ff <= '0;
         end else if (issue) begin
            scan_idx_ff <= scan_idx_ff + OCC_W'(1);
         end
         s1_vld_ff <= issue;
         s2_vld_ff <= s1_vld_ff;
         if (cmd.scan_clear) begin
            best_vld_ff <= 1'b0;
         end else if (better) begin
            best_vld_ff <= 1'b1;
         end
         if (cmd.tick_inc) begin
            pend_vld_ff <= 1'b0;
            emit_cnt_ff <= '0;
         end else if (cmd.take_best) begin
            pend_vld_ff <= 1'b1;
            emit_cnt_ff <= emit_cnt_ff + EMIT_W'(1);
         end else if (cmd.push && cmd.push_last) begin
            pend_vld_ff <= 1'b0;
         end
         if (cmd.push) begin
            rsp_vld_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_payload;
      end
      s1_idx_ff <= scan_idx_ff[IDX_W-1:0];
      age_ff    <= tick_ff - rd_deadline_ff;
      key2_ff   <= rd_key_ff;
      idx2_ff   <= s1_idx_ff;
      if (better) begin
         best_age_ff <= age_ff;
         best_key_ff <= key2_ff;
         best_idx_ff <= idx2_ff;
      end
      if (cmd.take_best) begin
         pend_key_ff <= best_key_ff;
      end
      if (cmd.push) begin
         rsp_ff <= rsp_in;
      end
   end

   assign status.in_sched   = (req_payload.cmd == CMD_SCHEDULE);
   assign status.full       = (occ_ff == OCC_W'(DEPTH));
   assign status.issue_done = issue_done;
   assign status.pipe_busy  = s1_vld_ff || s2_vld_ff;
   assign status.best_vld   = best_vld_ff;
   assign status.pend_vld   = pend_vld_ff;
   assign status.out_free   = !rsp_vld_ff || !rsp_stall;
   assign status.cnt_max    = (emit_cnt_ff == EMIT_W'(MAX_OUT));

   assign rsp_valid   = rsp_vld_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== src/tdq_controller.sv =====
// tdq_controller: state machine that sequences schedule, scan, pop and result steps.
// Depends on tdq_pkg; commands tdq_datapath and reads its status.

module tdq_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  tdq_pkg::ctl_status_type status,
   output tdq_pkg::ctl_cmd_type    cmd
);
   import tdq_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCHED  = 3'd1;
   localparam logic [2:0] ST_TICK   = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_DECIDE = 3'd4;
   localparam logic [2:0] ST_RM_RD  = 3'd5;
   localparam logic [2:0] ST_RM_WR  = 3'd6;
   localparam logic [2:0] ST_FLUSH  = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = status.in_sched ? ST_SCHED : ST_TICK;
            end
         end
         ST_SCHED: begin
            if (status.out_free) begin
               cmd.push = 1'b1;
               if (status.full) begin
                  cmd.push_src = PUSH_REJECT;
               end else begin
                  cmd.push_src    = PUSH_ACCEPT;
                  cmd.sched_write = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         ST_TICK: begin
            cmd.tick_inc   = 1'b1;
            cmd.scan_clear = 1'b1;
            state_in       = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (status.issue_done && !status.pipe_busy) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            // hand the previous pick out; the new pick waits until we know
            // whether another one follows
            if (status.out_free) begin
               if (status.pend_vld) begin
                  cmd.push      = 1'b1;
                  cmd.push_src  = PUSH_PEND;
                  cmd.push_last = !status.best_vld;
               end
               if (status.best_vld) begin
                  cmd.take_best = 1'b1;
                  state_in      = ST_RM_RD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_RM_RD: begin
            cmd.rm_read = 1'b1;
            state_in    = ST_RM_WR;
         end
         ST_RM_WR: begin
            cmd.rm_write = 1'b1;
            if (status.cnt_max) begin
               state_in = ST_FLUSH;
            end else begin
               cmd.scan_clear = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_FLUSH: begin
            if (status.out_free) begin
               cmd.push      = 1'b1;
               cmd.push_src  = PUSH_PEND;
               cmd.push_last = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
